/* rtl/pstc_pkg.sv */
// Shared types, token codes and word lookup for the token classifier.
package pstc_pkg;

  // Token kind codes
  localparam logic [3:0] KIND_KEYWORD = 4'd0;
  localparam logic [3:0] KIND_IDENT   = 4'd1;
  localparam logic [3:0] KIND_STRING  = 4'd2;
  localparam logic [3:0] KIND_NUMBER  = 4'd3;
  localparam logic [3:0] KIND_ASSIGN  = 4'd4;
  localparam logic [3:0] KIND_ARITH   = 4'd5;
  localparam logic [3:0] KIND_LOGICAL = 4'd6;
  localparam logic [3:0] KIND_LPAREN  = 4'd7;
  localparam logic [3:0] KIND_RPAREN  = 4'd8;
  localparam logic [3:0] KIND_COLON   = 4'd9;
  localparam logic [3:0] KIND_COMMA   = 4'd10;
  localparam logic [3:0] KIND_COMMENT = 4'd11;
  localparam logic [3:0] KIND_INDENT  = 4'd12;
  localparam logic [3:0] KIND_REL     = 4'd13;
  localparam logic [3:0] KIND_UNKNOWN = 4'd14;

  // Detail codes
  localparam logic [2:0] DET_NONE   = 3'd0;
  localparam logic [2:0] DET_ADD    = 3'd0;
  localparam logic [2:0] DET_SUB    = 3'd1;
  localparam logic [2:0] DET_DIV    = 3'd2;
  localparam logic [2:0] DET_MUL    = 3'd3;
  localparam logic [2:0] DET_MOD    = 3'd4;
  localparam logic [2:0] DET_REL_EQ = 3'd0;
  localparam logic [2:0] DET_REL_LT = 3'd1;
  localparam logic [2:0] DET_REL_LE = 3'd2;
  localparam logic [2:0] DET_REL_GT = 3'd3;
  localparam logic [2:0] DET_REL_GE = 3'd4;
  localparam logic [2:0] DET_REL_NT = 3'd5;
  localparam logic [2:0] DET_REL_NE = 3'd6;

  // Pending operator codes
  localparam logic [1:0] OP_EQ   = 2'd0;
  localparam logic [1:0] OP_LT   = 2'd1;
  localparam logic [1:0] OP_GT   = 2'd2;
  localparam logic [1:0] OP_BANG = 2'd3;

  // Default size of the line length cap
  localparam int MaxLineDefault = 256;

  // Letters of a word kept for lookup, first letter in the low byte
  localparam int PrefixChars = 5;
  localparam int PrefixWidth = 8 * PrefixChars;

  typedef struct packed {
    logic [7:0] ch;
    logic       last_in_line;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  detail;
    logic [15:0] line_index;
    logic [7:0]  start_column;
    logic [8:0]  token_length;
    logic        last_of_run;
  } out_item_t;

  // Tokens produced by one character, handed to the queue
  typedef struct packed {
    logic [1:0] n;
    out_item_t  t0;
    out_item_t  t1;
  } push_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [2:0] detail;
  } word_class_t;

  // Reserved word table: length, packed letters, kind and detail
  typedef struct packed {
    logic [2:0]             len;
    logic [PrefixWidth-1:0] letters;
    logic [3:0]             kind;
    logic [2:0]             detail;
  } word_entry_t;

  localparam int NumWords = 10;

  localparam word_entry_t WordTable [NumWords] = '{
    '{3'd3, 40'h00_00_64_6E_61, KIND_LOGICAL, 3'd0},  // and
    '{3'd2, 40'h00_00_00_72_6F, KIND_LOGICAL, 3'd1},  // or
    '{3'd3, 40'h00_00_74_6F_6E, KIND_LOGICAL, 3'd2},  // not
    '{3'd5, 40'h74_6E_69_72_70, KIND_KEYWORD, 3'd0},  // print
    '{3'd4, 40'h00_66_69_6C_65, KIND_KEYWORD, 3'd1},  // elif
    '{3'd2, 40'h00_00_00_66_69, KIND_KEYWORD, 3'd2},  // if
    '{3'd4, 40'h00_65_73_6C_65, KIND_KEYWORD, 3'd3},  // else
    '{3'd5, 40'h65_6C_69_68_77, KIND_KEYWORD, 3'd4},  // while
    '{3'd3, 40'h00_00_74_6E_69, KIND_KEYWORD, 3'd5},  // int
    '{3'd5, 40'h74_75_70_6E_69, KIND_KEYWORD, 3'd6}   // input
  };

  // Classify a finished letter run
  function automatic word_class_t word_class(logic [8:0] cnt, logic [PrefixWidth-1:0] prefix);
    word_class_t res;
    logic        hit;
    res = '{KIND_IDENT, DET_NONE};
    hit = 1'b0;
    for (int i = 0; i < NumWords; i++) begin
      if (!hit && cnt == {6'd0, WordTable[i].len} && prefix == WordTable[i].letters) begin
        hit = 1'b1;
        res = '{WordTable[i].kind, WordTable[i].detail};
      end
    end
    return res;
  endfunction

  function automatic out_item_t make_tok(logic [3:0] kind, logic [2:0] detail,
                                         logic [15:0] line, logic [7:0] start,
                                         logic [8:0] len);
    out_item_t t;
    t.kind         = kind;
    t.detail       = detail;
    t.line_index   = line;
    t.start_column = start;
    t.token_length = len;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

endpackage

/* rtl/pstc_scanner.sv */
// Scanner state and token generation for one character per cycle while go_i is high.
module pstc_scanner import pstc_pkg::*; #(
  parameter int MAX_LINE = MaxLineDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     go_i,
  input  in_item_t item_i,
  output push_t    push_o
);

  localparam int         LenCapInt = (MAX_LINE > 256) ? 256 : MAX_LINE;
  localparam logic [8:0] LenCap    = 9'(LenCapInt);
  localparam logic [7:0] ColCap    = 8'(LenCapInt - 1);

  typedef enum logic [5:0] {
    MODE_IDLE = 6'b000001,
    MODE_NUM  = 6'b000010,
    MODE_WORD = 6'b000100,
    MODE_STR  = 6'b001000,
    MODE_CMT  = 6'b010000,
    MODE_OP   = 6'b100000
  } mode_e;

  mode_e                  mode_q, mode_d;
  logic [7:0]             start_q, start_d;
  logic [8:0]             cnt_q, cnt_d;
  logic [PrefixWidth-1:0] prefix_q, prefix_d;
  logic                   quote_q, quote_d;
  logic [1:0]             pend_q, pend_d;
  logic [7:0]             col_q, col_d;
  logic [15:0]            line_q, line_d;
  logic                   lht_q, lht_d;

  logic [7:0]  c;
  logic        eol;
  logic        is_digit, is_alpha;
  logic [8:0]  cnt_inc;
  logic        used;
  logic        va, vb, vc;
  out_item_t   ta, tb, tc, t0, t1;
  word_class_t wa, wc;
  logic [2:0]  single_det, pair_det;
  logic [3:0]  single_kind;
  logic [1:0]  n_tok;

  assign c        = item_i.ch;
  assign eol      = item_i.last_in_line;
  assign is_digit = c inside {[8'h30:8'h39]};
  assign is_alpha = c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  assign cnt_inc  = (cnt_q < LenCap) ? cnt_q + 9'd1 : cnt_q;
  assign wa       = word_class(cnt_q, prefix_q);

  // Decode the pending operator alone and with a following '='
  always_comb begin
    single_kind = KIND_REL;
    case (pend_q)
      OP_EQ:   begin single_det = DET_REL_EQ; pair_det = DET_REL_EQ; single_kind = KIND_ASSIGN; end
      OP_LT:   begin single_det = DET_REL_LT; pair_det = DET_REL_LE; end
      OP_GT:   begin single_det = DET_REL_GT; pair_det = DET_REL_GE; end
      OP_BANG: begin single_det = DET_REL_NT; pair_det = DET_REL_NE; end
      default: begin single_det = DET_REL_NT; pair_det = DET_REL_NE; end
    endcase
  end

  // Close or extend the open run, then start on the character, then close at line end
  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    cnt_d    = cnt_q;
    prefix_d = prefix_q;
    quote_d  = quote_q;
    pend_d   = pend_q;
    col_d    = col_q;
    line_d   = line_q;
    lht_d    = lht_q;
    used     = 1'b0;
    va       = 1'b0;
    vb       = 1'b0;
    vc       = 1'b0;
    ta       = '0;
    tb       = '0;
    tc       = '0;
    wc       = '0;

    case (mode_q)
      MODE_STR: begin
        cnt_d = cnt_inc;
        used  = 1'b1;
        if (c == (quote_q ? 8'h27 : 8'h22)) begin
          va     = 1'b1;
          ta     = make_tok(KIND_STRING, DET_NONE, line_q, start_q, cnt_inc);
          mode_d = MODE_IDLE;
        end
      end
      MODE_CMT: begin
        cnt_d = cnt_inc;
        used  = 1'b1;
      end
      MODE_NUM: begin
        if (is_digit) begin
          cnt_d = cnt_inc;
          used  = 1'b1;
        end else begin
          va     = 1'b1;
          ta     = make_tok(KIND_NUMBER, DET_NONE, line_q, start_q, cnt_q);
          mode_d = MODE_IDLE;
        end
      end
      MODE_WORD: begin
        if (is_alpha) begin
          for (int i = 0; i < PrefixChars; i++) begin
            if (cnt_q == 9'(i)) prefix_d[8*i +: 8] = c;
          end
          cnt_d = cnt_inc;
          used  = 1'b1;
        end else begin
          va     = 1'b1;
          ta     = make_tok(wa.kind, wa.detail, line_q, start_q, cnt_q);
          mode_d = MODE_IDLE;
        end
      end
      MODE_OP: begin
        va = 1'b1;
        if (c == "=") begin
          ta   = make_tok(KIND_REL, pair_det, line_q, start_q, 9'd2);
          used = 1'b1;
        end else begin
          ta = make_tok(single_kind, single_det, line_q, start_q, 9'd1);
        end
        mode_d = MODE_IDLE;
      end
      default: mode_d = MODE_IDLE;
    endcase

    // Start a run or emit a one-character token
    if (!used) begin
      if (c == "#") begin
        mode_d = MODE_CMT; start_d = col_q; cnt_d = 9'd1;
      end else if (is_digit) begin
        mode_d = MODE_NUM; start_d = col_q; cnt_d = 9'd1;
      end else if (is_alpha) begin
        mode_d = MODE_WORD; start_d = col_q; cnt_d = 9'd1;
        prefix_d = {{(PrefixWidth-8){1'b0}}, c};
      end else if (c == 8'h22 || c == 8'h27) begin
        mode_d = MODE_STR; start_d = col_q; cnt_d = 9'd1;
        quote_d = (c == 8'h27);
      end else if (c == "(") begin
        vb = 1'b1; tb = make_tok(KIND_LPAREN, DET_NONE, line_q, col_q, 9'd1);
      end else if (c == ")") begin
        vb = 1'b1; tb = make_tok(KIND_RPAREN, DET_NONE, line_q, col_q, 9'd1);
      end else if (c == ",") begin
        vb = 1'b1; tb = make_tok(KIND_COMMA, DET_NONE, line_q, col_q, 9'd1);
      end else if (c == ":") begin
        vb = 1'b1; tb = make_tok(KIND_COLON, DET_NONE, line_q, col_q, 9'd1);
      end else if ((c == " " || c == 8'h09) && !(lht_q || va)) begin
        vb = 1'b1; tb = make_tok(KIND_INDENT, DET_NONE, line_q, col_q, 9'd1);
      end else if (c == "=" || c == "<" || c == ">" || c == "!") begin
        mode_d  = MODE_OP;
        start_d = col_q;
        pend_d  = (c == "=") ? OP_EQ : (c == "<") ? OP_LT : (c == ">") ? OP_GT : OP_BANG;
      end else if (c == "+") begin
        vb = 1'b1; tb = make_tok(KIND_ARITH, DET_ADD, line_q, col_q, 9'd1);
      end else if (c == "-") begin
        vb = 1'b1; tb = make_tok(KIND_ARITH, DET_SUB, line_q, col_q, 9'd1);
      end else if (c == "/") begin
        vb = 1'b1; tb = make_tok(KIND_ARITH, DET_DIV, line_q, col_q, 9'd1);
      end else if (c == "*") begin
        vb = 1'b1; tb = make_tok(KIND_ARITH, DET_MUL, line_q, col_q, 9'd1);
      end else if (c == "%") begin
        vb = 1'b1; tb = make_tok(KIND_ARITH, DET_MOD, line_q, col_q, 9'd1);
      end else if (c != " ") begin
        vb = 1'b1; tb = make_tok(KIND_UNKNOWN, DET_NONE, line_q, col_q, 9'd1);
      end
    end

    // Flush the open run at line end and advance the position
    wc = word_class(cnt_d, prefix_d);
    if (eol) begin
      case (mode_d)
        MODE_NUM: begin
          vc = 1'b1; tc = make_tok(KIND_NUMBER, DET_NONE, line_q, start_d, cnt_d);
        end
        MODE_WORD: begin
          vc = 1'b1; tc = make_tok(wc.kind, wc.detail, line_q, start_d, cnt_d);
        end
        MODE_STR: begin
          vc = 1'b1; tc = make_tok(KIND_STRING, DET_NONE, line_q, start_d, cnt_d);
        end
        MODE_CMT: begin
          vc = 1'b1; tc = make_tok(KIND_COMMENT, DET_NONE, line_q, start_d, cnt_d);
        end
        MODE_OP: begin
          vc = 1'b1;
          if (pend_d == OP_EQ) begin
            tc = make_tok(KIND_ASSIGN, DET_NONE, line_q, start_d, 9'd1);
          end else if (pend_d == OP_LT) begin
            tc = make_tok(KIND_REL, DET_REL_LT, line_q, start_d, 9'd1);
          end else if (pend_d == OP_GT) begin
            tc = make_tok(KIND_REL, DET_REL_GT, line_q, start_d, 9'd1);
          end else begin
            tc = make_tok(KIND_REL, DET_REL_NT, line_q, start_d, 9'd1);
          end
        end
        default: vc = 1'b0;
      endcase
      mode_d = MODE_IDLE;
      col_d  = '0;
      lht_d  = 1'b0;
      line_d = line_q + 16'd1;
    end else begin
      if (col_q < ColCap) col_d = col_q + 8'd1;
      lht_d = lht_q | va | vb;
    end
  end

  // Pack the tokens into two slots, marking the final one
  always_comb begin
    n_tok = 2'({1'b0, va} + {1'b0, vb} + {1'b0, vc});
    t0    = va ? ta : (vb ? tb : tc);
    t1    = (va && vb) ? tb : tc;
    if (n_tok == 2'd1) t0.last_of_run = 1'b1;
    if (n_tok == 2'd2) t1.last_of_run = 1'b1;
    push_o.n  = go_i ? n_tok : 2'd0;
    push_o.t0 = t0;
    push_o.t1 = t1;
  end

  // Hold scanner state, advance on each consumed character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      start_q  <= '0;
      cnt_q    <= '0;
      prefix_q <= '0;
      quote_q  <= 1'b0;
      pend_q   <= OP_EQ;
      col_q    <= '0;
      line_q   <= '0;
      lht_q    <= 1'b0;
    end else if (go_i) begin
      mode_q   <= mode_d;
      start_q  <= start_d;
      cnt_q    <= cnt_d;
      prefix_q <= prefix_d;
      quote_q  <= quote_d;
      pend_q   <= pend_d;
      col_q    <= col_d;
      line_q   <= line_d;
      lht_q    <= lht_d;
    end
  end

endmodule

/* rtl/pstc_token_queue.sv */
// Four-entry token queue taking up to two tokens and giving one per cycle while out_stall_i is low.
module pstc_token_queue import pstc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  output logic      room2_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  out_item_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q, wr_next;
  logic [PtrW:0]     count_q;
  logic              pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (count_q != '0);
  assign out_item_o  = mem_q[rd_q];
  assign room2_o     = (count_q <= (PtrW+1)'(Depth - 2));
  assign wr_next     = wr_q + PtrW'(1);

  // Write one or two tokens
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_q] <= push_i.t0;
    if (push_i.n == 2'd2) mem_q[wr_next] <= push_i.t1;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + PtrW'(push_i.n);
      if (pop) rd_q <= rd_q + PtrW'(1);
      count_q <= count_q + (PtrW+1)'(push_i.n) - (PtrW+1)'(pop);
    end
  end

endmodule

/* rtl/python_subset_token_classifier_unit.sv */
// Top level of the streaming token classifier for a small scripting language subset.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o   | in_item_i  (ch, last_in_line)
//  out     | output    | out_valid_o / out_stall_i | out_item_o (one token record)
//
//  One character is taken per cycle unless in_stall_o is high. It waits in an input
//  register until the scanner takes it and writes its zero, one or two tokens into
//  a four-entry queue that feeds the output. The input register holds while fewer
//  than two queue entries are free. The output moves one token a cycle unless
//  out_stall_i is high, so two-token characters eat queue slack and, back to back,
//  stall the input. Reset is asynchronous, active low; it clears scanner, queue, input.
module python_subset_token_classifier_unit import pstc_pkg::*; #(
  parameter int MAX_LINE = MaxLineDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic     in_valid_q;
  in_item_t in_item_q;
  logic     room2;
  logic     consume;
  logic     accept;
  push_t    push;

  assign consume    = in_valid_q && room2;
  assign in_stall_o = in_valid_q && !room2;
  assign accept     = in_valid_i && !in_stall_o;

  // Input register: load on accept, drop once consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_item_q <= in_item_i;
  end

  pstc_scanner #(
    .MAX_LINE (MAX_LINE)
  ) u_scanner (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (consume),
    .item_i (in_item_q),
    .push_o (push)
  );

  pstc_token_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // A held character stays put until the scanner takes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !consume) |=> (in_valid_q && $stable(in_item_q)))
    else $error("held input character changed before consume");

  // Tokens are only produced by a consumed character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n != 2'd0) |-> consume)
    else $error("tokens pushed without a consumed character");

  // Only the final token of a character carries the end-of-run mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n == 2'd2) |-> (!push.t0.last_of_run && push.t1.last_of_run))
    else $error("end-of-run mark on wrong token of a pair");

  // A delivered token always covers at least one character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.token_length != 9'd0))
    else $error("zero-length token delivered");

endmodule
